[design/subarray_target_sum_counter_defines.svh]
// assertion macros for the subarray target sum counter
`ifndef SUBARRAY_TARGET_SUM_COUNTER_DEFINES_SVH
`define SUBARRAY_TARGET_SUM_COUNTER_DEFINES_SVH
`ifndef SYNTH
// clocked check, off while in reset
`define STC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check, also during reset
`define STC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STC_ASSERT(label, clk, rst_n, prop, msg)
`define STC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[design/stc_pkg.sv]
// shared types and constants of the subarray target sum counter
package stc_pkg;
    localparam int TABLE_SIZE = 4096;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 64;
    localparam int CNT_W      = 32;
    localparam int TOTAL_W    = 63;
    localparam int CELL_W     = 16;
    localparam int NUM_CELLS  = KEY_W / CELL_W;
    localparam int STEP_W     = $clog2(NUM_CELLS + 1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               start_req;
    } t_in;

    typedef struct packed {
        logic [TOTAL_W-1:0] match_count;
        logic               table_full;
    } t_out;

    typedef struct packed {
        logic clr;
        logic start;
    } t_acc_ctrl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_DIFF,
        ST_CHK1,
        ST_ISSUE2,
        ST_CHK2,
        ST_WAIT
    } t_state;
endpackage

[design/stc_ram.sv]
// generic single write port ram with registered read
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/stc_acc_cell.sv]
// one slice of the match total accumulator
module stc_acc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic                      i_run,
    input  logic                      i_load,
    input  logic                      i_sat,
    input  logic [stc_pkg::CELL_W-1:0] i_addend,
    input  logic [stc_pkg::CELL_W-1:0] i_sat_val,
    input  logic                      i_carry,
    output logic [stc_pkg::CELL_W-1:0] o_sum,
    output logic                      o_carry
);
    logic [stc_pkg::CELL_W-1:0] r_sum;
    logic [stc_pkg::CELL_W-1:0] n_sum;
    logic                      r_carry;
    logic                      n_carry;
    logic [stc_pkg::CELL_W:0]   w_add;

    always_comb begin
        w_add   = {1'b0, r_sum} + {1'b0, (i_load ? i_addend : '0)}
                + {{stc_pkg::CELL_W{1'b0}}, i_carry};
        n_sum   = r_sum;
        n_carry = 1'b0;
        if (i_clr) begin
            n_sum = '0;
        end else if (i_sat) begin
            n_sum = i_sat_val;
        end else if (i_run) begin
            n_sum   = w_add[stc_pkg::CELL_W-1:0];
            n_carry = w_add[stc_pkg::CELL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_carry <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_carry <= n_carry;
        end
    end

    assign o_sum   = r_sum;
    assign o_carry = r_carry;
endmodule

[design/stc_acc_chain.sv]
// row of accumulator cells, carries move one cell per cycle, then saturate on overflow
`include "subarray_target_sum_counter_defines.svh"
module stc_acc_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stc_pkg::t_acc_ctrl          i_ctrl,
    input  logic [stc_pkg::CNT_W-1:0]   i_addend,
    output logic                        o_busy,
    output logic [stc_pkg::TOTAL_W-1:0] o_total
);
    localparam logic [stc_pkg::STEP_W-1:0] LastStep = stc_pkg::STEP_W'(stc_pkg::NUM_CELLS);

    logic [stc_pkg::KEY_W-1:0]    r_addend;
    logic [stc_pkg::KEY_W-1:0]    w_sum;
    logic [stc_pkg::KEY_W-1:0]    w_sat;
    logic [stc_pkg::NUM_CELLS-1:0] w_carry;
    logic                         r_busy;
    logic                         n_busy;
    logic [stc_pkg::STEP_W-1:0]   r_step;
    logic [stc_pkg::STEP_W-1:0]   n_step;
    logic                         w_run;
    logic                         w_sat_step;

    assign w_run      = r_busy && (r_step != LastStep);
    assign w_sat_step = r_busy && (r_step == LastStep) && w_sum[stc_pkg::KEY_W-1];
    assign w_sat      = {1'b0, {(stc_pkg::KEY_W-1){1'b1}}};

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (i_ctrl.clr) begin
            n_busy = 1'b0;
            n_step = '0;
        end else if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            if (r_step == LastStep) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_addend <= {{(stc_pkg::KEY_W-stc_pkg::CNT_W){1'b0}}, i_addend};
        end
    end

    for (genvar k = 0; k < stc_pkg::NUM_CELLS; k++) begin : g_cell
        logic w_cin;
        if (k == 0) begin : g_first
            assign w_cin = 1'b0;
        end else begin : g_next
            assign w_cin = w_carry[k-1];
        end
        stc_acc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clr     (i_ctrl.clr),
            .i_run     (w_run),
            .i_load    (r_step == '0),
            .i_sat     (w_sat_step),
            .i_addend  (r_addend[k*stc_pkg::CELL_W +: stc_pkg::CELL_W]),
            .i_sat_val (w_sat[k*stc_pkg::CELL_W +: stc_pkg::CELL_W]),
            .i_carry   (w_cin),
            .o_sum     (w_sum[k*stc_pkg::CELL_W +: stc_pkg::CELL_W]),
            .o_carry   (w_carry[k])
        );
    end

    assign o_busy  = r_busy;
    assign o_total = w_sum[stc_pkg::TOTAL_W-1:0];

    // the total never needs a carry out of the top cell
    `STC_ASSERT(a_no_top_carry, i_clk, i_rst_n, !w_carry[stc_pkg::NUM_CELLS-1], "top carry set")
    // a new add is never started while one is still in flight
    `STC_ASSERT(a_start_idle, i_clk, i_rst_n, i_ctrl.start |-> !r_busy, "add overlap")
endmodule

[design/subarray_target_sum_counter.sv]
// top level: prefix sum hash counter for subarrays that hit a target sum
//
// channel   direction  handshake          payload
// in        input      i_in_valid/stall   stc_pkg::t_in  (value, start_req)
// out       output     o_out_valid/stall  stc_pkg::t_out (match_count, table_full)
// cfg       input      i_cfg_valid/ready  target_sum, 64 bits signed
//
// after accept an item passes sum, diff, the first linear probe, issue2, the second
// linear probe and wait; each probe visits one slot a cycle on the table read port
// when the first probe hits, the wait also lasts until the add in the accumulator
// chain is done
// reset and any item with start_req run a clearing sweep over all TABLE_SIZE slots
// (4096) of the valid store before the item proceeds; no item is taken then
// the input is stalled from accept until the result is in the output register
// a result that is not taken holds; the next item may be accepted meanwhile
`include "subarray_target_sum_counter_defines.svh"
module subarray_target_sum_counter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  stc_pkg::t_in          i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output stc_pkg::t_out         o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  logic [63:0]           i_cfg_data,
    output logic                  o_cfg_ready
);
    localparam int DATA_W = stc_pkg::KEY_W + stc_pkg::CNT_W;
    localparam logic [stc_pkg::IDX_W-1:0] LastIdx = stc_pkg::IDX_W'(stc_pkg::TABLE_SIZE - 1);
    localparam logic [stc_pkg::CNT_W-1:0] CountMax = '1;

    stc_pkg::t_state r_state;
    stc_pkg::t_state n_state;

    // sequence state
    logic [stc_pkg::KEY_W-1:0]   r_target;
    logic [stc_pkg::KEY_W-1:0]   r_prefix;
    logic [stc_pkg::KEY_W-1:0]   r_diff;
    logic signed [31:0]          r_value;
    logic                        r_clr_item;   // sweep belongs to an item
    logic [stc_pkg::IDX_W-1:0]   r_clr;
    logic [stc_pkg::IDX_W-1:0]   r_idx;
    logic [stc_pkg::IDX_W-1:0]   r_probes;
    logic                        r_full;
    logic                        r_out_valid;
    stc_pkg::t_out               r_out;

    // table memories
    logic                        w_v_we;
    logic [stc_pkg::IDX_W-1:0]   w_v_waddr;
    logic                        w_v_wdata;
    logic                        w_v_rdata;
    logic                        w_d_we;
    logic [stc_pkg::IDX_W-1:0]   w_d_waddr;
    logic [DATA_W-1:0]           w_d_wdata;
    logic [DATA_W-1:0]           w_d_rdata;
    logic [stc_pkg::IDX_W-1:0]   w_raddr;
    logic [stc_pkg::KEY_W-1:0]   w_key;
    logic [stc_pkg::CNT_W-1:0]   w_count;
    logic [stc_pkg::KEY_W-1:0]   w_diff;
    logic                        w_hit;
    logic                        w_miss;
    logic                        w_last;

    // accumulator
    stc_pkg::t_acc_ctrl          w_acc;
    logic                        w_acc_busy;
    logic [stc_pkg::TOTAL_W-1:0] w_total;

    logic                        w_accept;
    logic                        w_out_load;

    assign w_key    = w_d_rdata[DATA_W-1 -: stc_pkg::KEY_W];
    assign w_count  = w_d_rdata[stc_pkg::CNT_W-1:0];
    assign w_diff   = r_prefix - r_target;
    assign w_miss   = !w_v_rdata;
    assign w_last   = (r_probes == LastIdx);
    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        w_hit = 1'b0;
        case (r_state)
            stc_pkg::ST_CHK1: w_hit = w_v_rdata && (w_key == r_diff);
            stc_pkg::ST_CHK2: w_hit = w_v_rdata && (w_key == r_prefix);
            default:          w_hit = 1'b0;
        endcase
    end

    // next state, memory and accumulator control
    always_comb begin
        n_state    = r_state;
        w_raddr    = r_idx + 1'b1;
        w_v_we     = 1'b0;
        w_v_waddr  = r_idx;
        w_v_wdata  = 1'b1;
        w_d_we     = 1'b0;
        w_d_waddr  = r_idx;
        w_d_wdata  = {r_prefix, w_count + 1'b1};
        w_acc      = '{clr: 1'b0, start: 1'b0};
        w_out_load = 1'b0;
        case (r_state)
            stc_pkg::ST_CLEAR: begin
                // the home slot of sum zero is slot zero, seeded with count one
                w_v_we    = 1'b1;
                w_v_waddr = r_clr;
                w_v_wdata = (r_clr == '0);
                w_d_we    = (r_clr == '0);
                w_d_waddr = '0;
                w_d_wdata = {{stc_pkg::KEY_W{1'b0}}, stc_pkg::CNT_W'(1)};
                w_acc.clr = 1'b1;
                if (r_clr == LastIdx) begin
                    n_state = r_clr_item ? stc_pkg::ST_SUM : stc_pkg::ST_IDLE;
                end
            end
            stc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_in_data.start_req ? stc_pkg::ST_CLEAR : stc_pkg::ST_SUM;
                end
            end
            stc_pkg::ST_SUM: begin
                n_state = stc_pkg::ST_DIFF;
            end
            stc_pkg::ST_DIFF: begin
                // home slot is the low bits of the key, also for negative keys
                w_raddr = w_diff[stc_pkg::IDX_W-1:0];
                n_state = stc_pkg::ST_CHK1;
            end
            stc_pkg::ST_CHK1: begin
                if (w_hit || w_miss || w_last) begin
                    w_acc.start = w_hit;
                    n_state     = stc_pkg::ST_ISSUE2;
                end
            end
            stc_pkg::ST_ISSUE2: begin
                w_raddr = r_prefix[stc_pkg::IDX_W-1:0];
                n_state = stc_pkg::ST_CHK2;
            end
            stc_pkg::ST_CHK2: begin
                if (w_hit) begin
                    w_d_we = (w_count != CountMax);
                    n_state = stc_pkg::ST_WAIT;
                end else if (w_miss) begin
                    w_d_we    = 1'b1;
                    w_d_wdata = {r_prefix, stc_pkg::CNT_W'(1)};
                    w_v_we    = 1'b1;
                    n_state   = stc_pkg::ST_WAIT;
                end else if (w_last) begin
                    n_state = stc_pkg::ST_WAIT;
                end
            end
            stc_pkg::ST_WAIT: begin
                if (!w_acc_busy && (!r_out_valid || !i_out_stall)) begin
                    w_out_load = 1'b1;
                    n_state    = stc_pkg::ST_IDLE;
                end
            end
            default: n_state = stc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stc_pkg::ST_CLEAR;
            r_clr_item  <= 1'b0;
            r_clr       <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
            if (r_state == stc_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_accept) begin
                r_clr_item <= i_in_data.start_req;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
        end else begin
            case (r_state)
                stc_pkg::ST_CLEAR: r_prefix <= '0;
                stc_pkg::ST_SUM: begin
                    r_prefix <= r_prefix + {{32{r_value[31]}}, r_value};
                end
                default: r_prefix <= r_prefix;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_in_data.value;
            r_full  <= 1'b0;
        end
        if (r_state == stc_pkg::ST_DIFF) begin
            r_diff <= w_diff;
        end
        if (r_state == stc_pkg::ST_DIFF || r_state == stc_pkg::ST_ISSUE2) begin
            r_idx    <= w_raddr;
            r_probes <= '0;
        end else if (r_state == stc_pkg::ST_CHK1 || r_state == stc_pkg::ST_CHK2) begin
            r_idx    <= w_raddr;
            r_probes <= r_probes + 1'b1;
        end
        if (r_state == stc_pkg::ST_CHK2 && !w_hit && !w_miss && w_last) begin
            r_full <= 1'b1;
        end
        if (w_out_load) begin
            r_out.match_count <= w_total;
            r_out.table_full  <= r_full;
        end
    end

    stc_ram #(.WIDTH(1), .DEPTH(stc_pkg::TABLE_SIZE)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (w_v_we),
        .i_waddr (w_v_waddr),
        .i_wdata (w_v_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_v_rdata)
    );

    stc_ram #(.WIDTH(DATA_W), .DEPTH(stc_pkg::TABLE_SIZE)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_d_rdata)
    );

    stc_acc_chain u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_acc),
        .i_addend (w_count),
        .o_busy   (w_acc_busy),
        .o_total  (w_total)
    );

    assign o_in_stall  = (r_state != stc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // table data is written only by the sweep or at the end of the second probe
    `STC_ASSERT(a_data_write, i_clk, i_rst_n,
        w_d_we |-> (r_state == stc_pkg::ST_CLEAR || r_state == stc_pkg::ST_CHK2),
        "stray table write")
    // a result enters the output register only with the accumulator settled
    `STC_ASSERT(a_load_settled, i_clk, i_rst_n, w_out_load |-> !w_acc_busy, "total not settled")
    // a fresh result never overwrites one that is still stalled
    `STC_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        (r_out_valid && i_out_stall) |=> $stable(r_out),
        "stalled result changed")
endmodule
